// ----- hw/rtl/xml_text_escaper_assert.svh -----
// Assertion macros for the XML text escaper checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef XML_TEXT_ESCAPER_ASSERT_SVH
`define XML_TEXT_ESCAPER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define XTE_ASSERT_IMPL(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("xte check failed: implication");

// Check that a condition implies a consequence in the next cycle.
`define XTE_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("xte check failed: next cycle");

`endif

// ----- hw/rtl/xte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types, constants and escape tables for the XML text escaper.
// ----------------------------------------------------------------------------
package xte_pkg;

    localparam logic [15:0] BUF_SIZE_RESET = 16'd1024;

    // Job queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Characters
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_U    = 8'h75;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_AMP  = 3'd1,
        KIND_LT   = 3'd2,
        KIND_GT   = 3'd3,
        KIND_QUOT = 3'd4,
        KIND_BYTE = 3'd5
    } kind_t;

    // One classified input byte: optional leading backslash, body, optional terminator
    typedef struct packed {
        logic       bs;
        kind_t      kind;
        logic [7:0] val;
        logic       term;
    } job_t;

    function automatic logic [2:0] seq_len(input kind_t kind);
        logic [2:0] len;
        begin
            unique case (kind)
                KIND_AMP:  len = 3'd5;
                KIND_LT:   len = 3'd4;
                KIND_GT:   len = 3'd4;
                KIND_QUOT: len = 3'd6;
                KIND_BYTE: len = 3'd1;
                default:   len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] seq_char(input kind_t kind, input logic [2:0] idx,
                                            input logic [7:0] val);
        logic [7:0] c;
        begin
            c = CH_NUL;
            unique case (kind)
                KIND_AMP: begin
                    case (idx)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = CH_A;
                        3'd2:    c = CH_M;
                        3'd3:    c = CH_P;
                        default: c = CH_SEMI;
                    endcase
                end
                KIND_LT: begin
                    case (idx)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = CH_L;
                        3'd2:    c = CH_T;
                        default: c = CH_SEMI;
                    endcase
                end
                KIND_GT: begin
                    case (idx)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = CH_G;
                        3'd2:    c = CH_T;
                        default: c = CH_SEMI;
                    endcase
                end
                KIND_QUOT: begin
                    case (idx)
                        3'd0:    c = CH_AMP;
                        3'd1:    c = CH_Q;
                        3'd2:    c = CH_U;
                        3'd3:    c = CH_O;
                        3'd4:    c = CH_T;
                        default: c = CH_SEMI;
                    endcase
                end
                KIND_BYTE: c = val;
                default:   c = CH_NUL;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- hw/rtl/xte_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xte_front
// Accepts input bytes, tracks buffer room and string state, and turns each
// byte into at most one job for the back end.
// ----------------------------------------------------------------------------
module xte_front
    import xte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        q_ready,
    output logic        q_push,
    output job_t        q_job
);

    logic [15:0] buf_size_reg;
    logic [15:0] bytes_written_reg, bytes_written_next;
    logic        held_reg, held_next;
    logic        stopped_reg, stopped_next;
    logic        accept;
    job_t        job;
    logic [15:0] cap;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign cap      = (buf_size_reg == 16'd0) ? 16'd0 : buf_size_reg - 16'd1;

    always_comb
    begin
        logic [15:0] bw_a;
        logic        consumed;
        logic        stop_a;
        logic [2:0]  len;
        logic [16:0] end_pos;
        begin
            job          = '{bs: 1'b0, kind: KIND_NONE, val: in_byte, term: 1'b0};
            bw_a         = bytes_written_reg;
            consumed     = 1'b0;
            stop_a       = stopped_reg;
            held_next    = held_reg;
            len          = 3'd0;
            end_pos      = 17'd0;

            // Resolve a backslash left over from the previous byte
            if (held_reg) begin
                held_next = 1'b0;
                if (bytes_written_reg >= cap) begin
                    stop_a = 1'b1;
                end else if (in_byte == CH_N) begin
                    job.kind = KIND_BYTE;
                    job.val  = CH_NL;
                    bw_a     = bytes_written_reg + 16'd1;
                    consumed = 1'b1;
                end else begin
                    job.bs = 1'b1;
                    bw_a   = bytes_written_reg + 16'd1;
                end
            end

            bytes_written_next = bw_a;
            stopped_next       = stop_a;

            if (in_byte == CH_NUL) begin
                job.term           = 1'b1;
                bytes_written_next = 16'd0;
                held_next          = 1'b0;
                stopped_next       = 1'b0;
            end else if (!consumed && !stop_a) begin
                if (bw_a >= cap) begin
                    stopped_next = 1'b1;
                end else if (in_byte == CH_BSL) begin
                    held_next = 1'b1;
                end else begin
                    case (in_byte)
                        CH_AMP:  job.kind = KIND_AMP;
                        CH_LT:   job.kind = KIND_LT;
                        CH_GT:   job.kind = KIND_GT;
                        CH_QUOT: job.kind = KIND_QUOT;
                        default: job.kind = KIND_BYTE;
                    endcase
                    len     = seq_len(job.kind);
                    end_pos = {1'b0, bw_a} + 17'(len);
                    // Drop the whole escape or byte if it does not fit
                    if (end_pos > {1'b0, cap}) begin
                        job.kind     = KIND_NONE;
                        stopped_next = 1'b1;
                    end else begin
                        bytes_written_next = end_pos[15:0];
                    end
                end
            end
        end
    end

    assign q_job  = job;
    assign q_push = accept && (job.bs || job.term || (job.kind != KIND_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_size_reg      <= BUF_SIZE_RESET;
            bytes_written_reg <= 16'd0;
            held_reg          <= 1'b0;
            stopped_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                buf_size_reg <= cfg_wr_data;
            end
            if (accept) begin
                bytes_written_reg <= bytes_written_next;
                held_reg          <= held_next;
                stopped_reg       <= stopped_next;
            end
        end
    end

endmodule

// ----- hw/rtl/xte_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xte_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module xte_queue
    import xte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic push_ready,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    job_t              slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/xte_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xte_back
// Expands the job at the queue head into output beats, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module xte_back
    import xte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    logic [2:0] pos_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       string_done_reg;

    logic       load;
    logic [2:0] len;
    logic [3:0] total;
    logic [2:0] body_idx;
    logic       in_prefix;
    logic       is_term;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign load = job_valid && (!out_valid_reg || out_ready);
    assign len  = seq_len(job.kind);
    assign total = 4'(job.bs) + 4'(len) + 4'(job.term);

    always_comb
    begin
        in_prefix = job.bs && (pos_reg == 3'd0);
        body_idx  = job.bs ? pos_reg - 3'd1 : pos_reg;
        is_term   = !in_prefix && (body_idx >= len);
        if (in_prefix) begin
            cur_byte = CH_BSL;
        end else if (is_term) begin
            cur_byte = CH_NUL;
        end else begin
            cur_byte = seq_char(job.kind, body_idx, job.val);
        end
        cur_last = ({1'b0, pos_reg} == total - 4'd1);
    end

    assign job_pop = load && cur_last;

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg    <= cur_byte;
            run_last_reg    <= cur_last;
            string_done_reg <= is_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= cur_last ? 3'd0 : pos_reg + 3'd1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = string_done_reg;

endmodule

// ----- hw/rtl/xml_text_escaper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_text_escaper
// Streaming XML text escaper: escapes & < > " , folds backslash-n into a
// newline and limits each string to the configured buffer size.
// ----------------------------------------------------------------------------
//  channel   signals                                   accepted when
//  input     in_valid, in_ready, in_byte               in_valid && in_ready
//  output    out_valid, out_ready, out_byte,           out_valid && out_ready
//            run_last, string_done
//  config    cfg_wr_en, cfg_wr_data (buffer_size)      cfg_wr_en
//
//  The front takes one byte per cycle while the two-entry job queue has room.
//  The back emits one output beat per cycle unless the output stalls. A byte
//  that maps to one byte takes one beat, an escape one per character, and a
//  leading backslash one more; the single byte sequencer sets the sustained rate.
//  Reset is asynchronous; buffer_size returns to 1024 and all string state clears.
//  A stalled output holds the back end; the queue lets the front run ahead.
module xml_text_escaper
    import xte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        string_done
);

    logic q_ready;
    logic q_push;
    job_t q_job;
    logic head_valid;
    job_t head_job;
    logic head_pop;

    xte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_job       (q_job)
    );

    xte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .push_ready (q_ready),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_job    (head_job)
    );

    xte_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (head_valid),
        .job         (head_job),
        .job_pop     (head_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

// ----- hw/rtl/xte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xte_checker
// Port-level checks for the XML text escaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "xml_text_escaper_assert.svh"

module xte_checker
    import xte_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_done
);

    // A stalled output beat stays up
    `XTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // The terminator is zero and closes its input byte's run
    `XTE_ASSERT_IMPL(a_term_shape, out_valid && string_done, out_byte == CH_NUL && run_last)

    // Only the terminator carries a zero byte
    `XTE_ASSERT_IMPL(a_zero_is_term, out_valid && out_byte == CH_NUL, string_done)

    // An escape opener never ends a run
    `XTE_ASSERT_IMPL(a_amp_not_last, out_valid && out_byte == CH_AMP, !run_last)

endmodule

bind xml_text_escaper xte_checker u_xte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_done (string_done)
);
